/* src/rv32alu_pkg.sv */
// ---------------------------------------------------------------------------
// rv32alu_pkg
// Shared constants, operation codes and types of the RV32I register ALU
// execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rv32alu_pkg;

    // register file geometry
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int IDX_W     = 5;
    localparam int XLEN      = 32;
    localparam int SHAMT_W   = 5;

    localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

    // operation codes
    localparam logic [3:0] OP_ADD       = 4'd0;
    localparam logic [3:0] OP_SUB       = 4'd1;
    localparam logic [3:0] OP_SLL       = 4'd2;
    localparam logic [3:0] OP_SLT       = 4'd3;
    localparam logic [3:0] OP_SLTU      = 4'd4;
    localparam logic [3:0] OP_XOR       = 4'd5;
    localparam logic [3:0] OP_SRL       = 4'd6;
    localparam logic [3:0] OP_SRA       = 4'd7;
    localparam logic [3:0] OP_OR        = 4'd8;
    localparam logic [3:0] OP_AND       = 4'd9;
    localparam logic [3:0] OP_WRITEBACK = 4'd10;

    // register file write request
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [XLEN-1:0]       data;
    } t_wr_req;

    // side effects of one operation
    typedef struct packed {
        logic wr_en;
        logic pc_adv;
    } t_alu_flags;

    // true for a register that really exists and is not hard-wired zero
    function automatic logic reg_live(input logic [IDX_W-1:0] idx);
        reg_live = (idx != '0) && ((IDX_W + 1)'(idx) < (IDX_W + 1)'(REG_COUNT));
    endfunction

endpackage

`default_nettype wire

/* src/rv32i_register_alu_execute_unit.sv */
// ---------------------------------------------------------------------------
// rv32i_register_alu_execute_unit
// Executes RV32I register-register ALU instructions on a 32 x 32-bit
// register file and tracks the program counter.
// ---------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel: an operation code, rd, rs1,
//   rs2 and a value that only the writeback operation loads into rd.
//   Each item gives exactly one result item on m_axis: the value computed
//   for rd and the program counter after the item.
//   The register file read data is registered at the accepting edge, and
//   the ALU result and the write back into the memory when the item
//   leaves the read stage. Throughput is one item per cycle while the
//   receiver does not stall; a write at the same edge as a read of the
//   same register is bypassed into the read data register.
//   Reset clears the program counter and the valid bits of the register
//   file, so every register reads zero afterwards; no clearing pass.
//   When the receiver stalls, the result stays in the output register, the
//   item behind it waits in the read stage and s_axis_tready drops once
//   both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32i_register_alu_execute_unit
    import rv32alu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // operation[3:0], dest_index[8:4], src1_index[13:9], src2_index[18:14],
    // write_value[50:19], zero pad[55:51]
    input  wire logic [55:0] s_axis_tdata,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // rd_value[31:0], next_pc[63:32]
    output      logic [63:0] m_axis_tdata
);

    // read stage
    logic             r_s1_valid;
    logic [3:0]       r_s1_op;
    logic [IDX_W-1:0] r_s1_rd;
    logic [XLEN-1:0]  r_s1_wval;

    // output stage and program counter
    logic             r_out_valid;
    logic [XLEN-1:0]  r_out_rd_value;
    logic [XLEN-1:0]  r_out_pc;
    logic [XLEN-1:0]  r_pc;
    logic [XLEN-1:0]  n_pc;

    logic             s1_go;
    logic             accept;
    logic             s1_fire;
    logic [XLEN-1:0]  rs1_data;
    logic [XLEN-1:0]  rs2_data;
    logic [XLEN-1:0]  alu_result;
    t_alu_flags       alu_flags;
    t_wr_req          wr;

    // handshake
    assign s1_go         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_fire       = r_s1_valid && s1_go;

    // register file
    rv32alu_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rs1      (s_axis_tdata[13:9]),
        .i_rs2      (s_axis_tdata[18:14]),
        .i_wr       (wr),
        .o_rs1_data (rs1_data),
        .o_rs2_data (rs2_data)
    );

    // alu
    rv32alu_alu u_alu (
        .i_op     (r_s1_op),
        .i_a      (rs1_data),
        .i_b      (rs2_data),
        .i_wval   (r_s1_wval),
        .o_result (alu_result),
        .o_flags  (alu_flags)
    );

    // write back, writes to x0 or absent registers dropped
    always_comb begin
        wr.en   = s1_fire && alu_flags.wr_en && reg_live(r_s1_rd);
        wr.idx  = r_s1_rd;
        wr.data = alu_result;
    end

    assign n_pc = r_pc + PC_STEP;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s1_go) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire && alu_flags.pc_adv) begin
                r_pc <= n_pc;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= s_axis_tdata[3:0];
            r_s1_rd   <= s_axis_tdata[8:4];
            r_s1_wval <= s_axis_tdata[50:19];
        end
        if (s1_fire) begin
            r_out_rd_value <= alu_result;
            r_out_pc       <= alu_flags.pc_adv ? n_pc : r_pc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pc, r_out_rd_value};

    // the memory is never written at x0
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (wr.idx != '0))
        else $error("register file write to x0");

    // the program counter only ever steps by four
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_pc != $past(r_pc))) |-> (r_pc == $past(r_pc) + PC_STEP))
        else $error("program counter moved by other than one step");

    // an accepted item always occupies the read stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item lost before the read stage");

endmodule

`default_nettype wire

/* src/rv32alu_regfile.sv */
// ---------------------------------------------------------------------------
// rv32alu_regfile
// Register file memory with one write port and two registered read ports,
// per-entry valid bits for reset-to-zero and write-first bypass.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32alu_regfile
    import rv32alu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [IDX_W-1:0]  i_rs1,
    input  wire logic [IDX_W-1:0]  i_rs2,
    input  wire t_wr_req           i_wr,
    output      logic [XLEN-1:0]   o_rs1_data,
    output      logic [XLEN-1:0]   o_rs2_data
);

    logic [XLEN-1:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;

    logic [XLEN-1:0] r_q1;
    logic [XLEN-1:0] r_q2;
    logic            r_ok1;
    logic            r_ok2;
    logic            r_fw1;
    logic            r_fw2;
    logic [XLEN-1:0] r_fw_data;

    logic [REG_IDX_W-1:0] rs1_a;
    logic [REG_IDX_W-1:0] rs2_a;
    logic [REG_IDX_W-1:0] wr_a;

    assign rs1_a = i_rs1[REG_IDX_W-1:0];
    assign rs2_a = i_rs2[REG_IDX_W-1:0];
    assign wr_a  = i_wr.idx[REG_IDX_W-1:0];

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[wr_a] <= 1'b1;
        end
    end

    // memory write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_a] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q1      <= r_mem[rs1_a];
            r_q2      <= r_mem[rs2_a];
            r_ok1     <= reg_live(i_rs1) && r_valid[rs1_a];
            r_ok2     <= reg_live(i_rs2) && r_valid[rs2_a];
            r_fw1     <= i_wr.en && (i_wr.idx == i_rs1);
            r_fw2     <= i_wr.en && (i_wr.idx == i_rs2);
            r_fw_data <= i_wr.data;
        end
    end

    // bypass and zero for unwritten or absent registers
    always_comb begin
        o_rs1_data = r_fw1 ? r_fw_data : (r_ok1 ? r_q1 : '0);
        o_rs2_data = r_fw2 ? r_fw_data : (r_ok2 ? r_q2 : '0);
    end

endmodule

`default_nettype wire

/* src/rv32alu_alu.sv */
// ---------------------------------------------------------------------------
// rv32alu_alu
// Arithmetic and logic unit for the RV32I register-register operations and
// the writeback load.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32alu_alu
    import rv32alu_pkg::*;
(
    input  wire logic [3:0]       i_op,
    input  wire logic [XLEN-1:0]  i_a,
    input  wire logic [XLEN-1:0]  i_b,
    input  wire logic [XLEN-1:0]  i_wval,
    output      logic [XLEN-1:0]  o_result,
    output      t_alu_flags       o_flags
);

    logic [SHAMT_W-1:0] shamt;

    assign shamt = i_b[SHAMT_W-1:0];

    // operation decode
    always_comb begin
        o_result       = '0;
        o_flags.wr_en  = 1'b1;
        o_flags.pc_adv = 1'b1;
        unique case (i_op)
            OP_ADD:  o_result = i_a + i_b;
            OP_SUB:  o_result = i_a - i_b;
            OP_SLL:  o_result = i_a << shamt;
            OP_SLT:  o_result = XLEN'($signed(i_a) < $signed(i_b));
            OP_SLTU: o_result = XLEN'(i_a < i_b);
            OP_XOR:  o_result = i_a ^ i_b;
            OP_SRL:  o_result = i_a >> shamt;
            OP_SRA:  o_result = XLEN'($signed(i_a) >>> shamt);
            OP_OR:   o_result = i_a | i_b;
            OP_AND:  o_result = i_a & i_b;
            OP_WRITEBACK: begin
                o_result       = i_wval;
                o_flags.pc_adv = 1'b0;
            end
            default: begin
                o_result       = '0;
                o_flags.wr_en  = 1'b0;
                o_flags.pc_adv = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the rv32i register alu execute unit. Items are
// streamed in with random gaps and results drained with random stalls,
// including one long output hold-off. A scoreboard keeps its own register
// file and program counter, predicts every result and checks each
// returned item in order.
// ---------------------------------------------------------------------------
module tb;
    import rv32alu_pkg::*;

    // opcodes the unit must ignore
    localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    // one instruction item, opcode in the low bits
    typedef struct packed {
        logic [31:0] wval;
        logic [4:0]  rs2;
        logic [4:0]  rs1;
        logic [4:0]  rd;
        logic [3:0]  op;
    } t_alu_item;

    // one retired instruction, rd value in the low bits
    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] rd_value;
    } t_alu_result;

    // shadow register file and pc, plus the retirements still owed
    class rv32_retire_scoreboard;
        logic [31:0] gpr [32];
        logic [31:0] pc;
        t_alu_result retire_q [$];
        int unsigned mismatches;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            pc = '0;
            mismatches = 0;
        endfunction

        function logic [31:0] read_gpr(input logic [4:0] idx);
            if (idx == '0 || int'(idx) >= REG_COUNT)
                return '0;
            return gpr[idx];
        endfunction

        // execute one accepted instruction on the shadow state
        function void issue(input t_alu_item it);
            logic [31:0] a;
            logic [31:0] b;
            logic [4:0]  sh;
            logic [31:0] r;
            logic        wr;
            logic        adv;
            t_alu_result res;
            a   = read_gpr(it.rs1);
            b   = read_gpr(it.rs2);
            sh  = b[4:0];
            wr  = 1'b1;
            adv = 1'b1;
            case (it.op)
                OP_ADD:       r = a + b;
                OP_SUB:       r = a - b;
                OP_SLL:       r = a << sh;
                OP_SLT:       r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                OP_SLTU:      r = (a < b) ? 32'd1 : 32'd0;
                OP_XOR:       r = a ^ b;
                OP_SRL:       r = a >> sh;
                OP_SRA:       r = $signed(a) >>> sh;
                OP_OR:        r = a | b;
                OP_AND:       r = a & b;
                OP_WRITEBACK: begin
                    r   = it.wval;
                    adv = 1'b0;
                end
                default: begin
                    r   = '0;
                    wr  = 1'b0;
                    adv = 1'b0;
                end
            endcase
            // x0 and missing registers swallow the write
            if (wr && it.rd != '0 && int'(it.rd) < REG_COUNT)
                gpr[it.rd] = r;
            if (adv)
                pc = pc + 32'd4;
            res.rd_value = r;
            res.next_pc  = pc;
            retire_q.push_back(res);
        endfunction

        // compare a returned item with the oldest prediction
        function void retire(input t_alu_result got);
            t_alu_result exp;
            if (retire_q.size() == 0) begin
                $error("result item with no instruction outstanding: %h", got);
                mismatches++;
                return;
            end
            exp = retire_q.pop_front();
            if (got.rd_value !== exp.rd_value) begin
                $error("rd_value: expected %h, got %h", exp.rd_value, got.rd_value);
                mismatches++;
            end
            if (got.next_pc !== exp.next_pc) begin
                $error("next_pc: expected %h, got %h", exp.next_pc, got.next_pc);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // operation[3:0], dest_index[8:4], src1_index[13:9], src2_index[18:14],
    // write_value[50:19], zero pad[55:51]
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // rd_value[31:0], next_pc[63:32]
    logic [63:0] m_axis_tdata;

    rv32_retire_scoreboard sb = new();

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit hold_outputs = 1'b0;
    int quiet_cycles = 0;

    rv32i_register_alu_execute_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // handshake monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.issue(t_alu_item'(s_axis_tdata[50:0]));
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.retire(t_alu_result'(m_axis_tdata));
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic t_alu_item make_item(input logic [3:0] op, input logic [4:0] rd,
                                            input logic [4:0] rs1, input logic [4:0] rs2,
                                            input logic [31:0] wval);
        t_alu_item it;
        it.op   = op;
        it.rd   = rd;
        it.rs1  = rs1;
        it.rs2  = rs2;
        it.wval = wval;
        return it;
    endfunction

    // indices lean towards a few registers so back-to-back hazards are common
    function automatic logic [4:0] pick_index();
        if ($urandom_range(0, 9) < 4)
            return 5'($urandom_range(0, 3));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'($urandom_range(0, 40));
            default: return 32'($urandom);
        endcase
    endfunction

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(input t_alu_item it);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, it};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // result drain with random stalls and one long hold-off
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 50 == 0)
                recv_idle = ($urandom_range(0, 3) != 0);
            if (hold_outputs) begin
                stall = HOLD_CYCLES;
                hold_outputs = 1'b0;
            end else begin
                stall = recv_idle ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // stimulus
    initial begin
        t_alu_item it;
        int sel;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill some registers with the corner values
        send_item(make_item(OP_WRITEBACK, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF));
        send_item(make_item(OP_WRITEBACK, 5'd2, 5'd31, 5'd31, 32'h8000_0000));
        send_item(make_item(OP_WRITEBACK, 5'd3, 5'd0, 5'd0, 32'hFFFF_FFFF));
        send_item(make_item(OP_WRITEBACK, 5'd4, 5'd0, 5'd0, 32'h0000_0001));
        send_item(make_item(OP_WRITEBACK, 5'd5, 5'd0, 5'd0, 32'd31));
        // shift amount taken from low five bits only
        send_item(make_item(OP_WRITEBACK, 5'd31, 5'd0, 5'd0, 32'hAAAA_AAA3));
        // write to x0 is dropped
        send_item(make_item(OP_WRITEBACK, 5'd0, 5'd0, 5'd0, 32'hDEAD_BEEF));
        // every alu operation, with wrap and sign corners
        send_item(make_item(OP_ADD, 5'd6, 5'd1, 5'd4, '0));
        send_item(make_item(OP_SUB, 5'd7, 5'd2, 5'd4, '0));
        send_item(make_item(OP_SLL, 5'd8, 5'd3, 5'd5, '0));
        send_item(make_item(OP_SLT, 5'd9, 5'd2, 5'd1, '0));
        send_item(make_item(OP_SLTU, 5'd10, 5'd2, 5'd1, '0));
        send_item(make_item(OP_XOR, 5'd11, 5'd3, 5'd31, '0));
        send_item(make_item(OP_SRL, 5'd12, 5'd2, 5'd5, '0));
        send_item(make_item(OP_SRA, 5'd13, 5'd2, 5'd5, '0));
        send_item(make_item(OP_SRA, 5'd14, 5'd1, 5'd31, '0));
        send_item(make_item(OP_OR, 5'd15, 5'd0, 5'd31, '0));
        // alu result aimed at x0 is still reported
        send_item(make_item(OP_AND, 5'd0, 5'd3, 5'd31, '0));
        send_item(make_item(OP_ADD, 5'd16, 5'd0, 5'd0, 32'hFFFF_FFFF));
        // unused opcodes leave state alone
        send_item(make_item(OP_FIRST_UNUSED, 5'd20, 5'd1, 5'd2, 32'h1234_5678));
        send_item(make_item(OP_LAST_UNUSED, 5'd21, 5'd3, 5'd3, 32'hFFFF_FFFF));
        // read right behind the write that produced it
        send_item(make_item(OP_ADD, 5'd22, 5'd6, 5'd6, '0));
        send_item(make_item(OP_WRITEBACK, 5'd31, 5'd0, 5'd0, 32'h0000_0000));
        send_item(make_item(OP_SLL, 5'd23, 5'd3, 5'd31, '0));

        // random instruction stream
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                send_idle = ($urandom_range(0, 3) != 0);
            if (n == 400) begin
                hold_outputs = 1'b1;
                send_idle = 1'b0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70)
                it.op = 4'($urandom_range(OP_ADD, OP_AND));
            else if (sel < 95)
                it.op = OP_WRITEBACK;
            else
                it.op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            it.rd   = pick_index();
            it.rs1  = pick_index();
            it.rs2  = pick_index();
            it.wval = pick_value();
            send_item(it);
        end
        s_axis_tvalid <= 1'b0;

        // let the monitor note the last item, drain, then watch for strays
        @(posedge i_clk);
        while (sb.retire_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.retire_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
